@@ rtl/etf_pkg.sv @@
// Shared types and codes for the escape-time fractal iterator.
package etf_pkg;

    localparam int LANES = 5;

    typedef enum logic [2:0] {
        CFG_KIND   = 3'd0,
        CFG_SCALE  = 3'd1,
        CFG_XOFF   = 3'd2,
        CFG_YOFF   = 3'd3,
        CFG_JRE    = 3'd4,
        CFG_JIM    = 3'd5,
        CFG_LIMIT  = 3'd6,
        CFG_NONE   = 3'd7
    } t_cfg_idx;

    typedef enum logic [2:0] {
        KIND_MANDEL       = 3'd0,
        KIND_CONJ_MANDEL  = 3'd1,
        KIND_CUBIC        = 3'd2,
        KIND_CONJ_CUBIC   = 3'd3,
        KIND_QUARTIC      = 3'd4,
        KIND_CONJ_QUARTIC = 3'd5,
        KIND_JULIA        = 3'd6,
        KIND_CONJ_JULIA   = 3'd7
    } t_kind;

endpackage

@@ rtl/etf_cell.sv @@
// One cell of the iteration ring: squares, cross products, or combine and add.
module etf_cell import etf_pkg::*; #(
    parameter int W     = 32,
    parameter int F     = 26,
    parameter int STAGE = 0
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic                         i_load,
    input  t_kind                        i_kind,
    input  logic [LANES-1:0][W-1:0]      i_lanes,
    input  logic [LANES-1:0][W-1:0]      i_load_lanes,
    input  logic signed [W-1:0]          i_ax,
    input  logic signed [W-1:0]          i_ay,
    output logic [LANES-1:0][W-1:0]      o_lanes,
    output logic                         o_escape
);

    localparam int SW = 2 * W + 1;
    localparam logic signed [SW-1:0] MAXV = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [SW-1:0] MINV = ~MAXV;
    localparam logic signed [SW-1:0] FOUR =
        (F + 2 < W - 1) ? (SW'(1) <<< (F + 2)) : MAXV;

    function automatic logic signed [W-1:0] sat(input logic signed [SW-1:0] v);
        if (v > MAXV) return MAXV[W-1:0];
        if (v < MINV) return MINV[W-1:0];
        return v[W-1:0];
    endfunction

    function automatic logic signed [W-1:0] add(input logic signed [W-1:0] a,
                                                input logic signed [W-1:0] b);
        return sat(SW'(a) + SW'(b));
    endfunction

    function automatic logic signed [W-1:0] sub(input logic signed [W-1:0] a,
                                                input logic signed [W-1:0] b);
        return sat(SW'(a) - SW'(b));
    endfunction

    function automatic logic signed [W-1:0] neg(input logic signed [W-1:0] a);
        return sat(-SW'(a));
    endfunction

    function automatic logic signed [W-1:0] x3(input logic signed [W-1:0] a);
        return sat(SW'(a) + SW'(a) + SW'(a));
    endfunction

    function automatic logic signed [W-1:0] x4(input logic signed [W-1:0] a);
        return sat(SW'(a) <<< 2);
    endfunction

    function automatic logic signed [W-1:0] mul(input logic signed [W-1:0] a,
                                                input logic signed [W-1:0] b);
        logic signed [2*W-1:0] p;
        p = a * b;
        return sat(SW'(p >>> F));
    endfunction

    logic [LANES-1:0][W-1:0] r_lanes;
    logic [LANES-1:0][W-1:0] n_lanes;
    logic                    conj;
    logic                    cubic;
    logic                    quartic;

    assign conj    = i_kind[0];
    assign cubic   = (i_kind == KIND_CUBIC) || (i_kind == KIND_CONJ_CUBIC);
    assign quartic = (i_kind == KIND_QUARTIC) || (i_kind == KIND_CONJ_QUARTIC);

    generate
        if (STAGE == 0) begin : g_square
            logic signed [W-1:0] x, y;
            assign x = i_lanes[0];
            assign y = i_lanes[1];
            always_comb begin
                n_lanes    = '0;
                n_lanes[0] = mul(x, x);
                n_lanes[1] = mul(y, y);
                n_lanes[2] = mul(x, y);
                n_lanes[3] = x;
                n_lanes[4] = y;
            end
            assign o_escape = 1'b0;
        end else if (STAGE == 1) begin : g_cross
            logic signed [W-1:0] x2, y2, xy, x, y, d;
            assign x2 = i_lanes[0];
            assign y2 = i_lanes[1];
            assign xy = i_lanes[2];
            assign x  = i_lanes[3];
            assign y  = i_lanes[4];
            assign d  = sub(x2, y2);
            assign o_escape = SW'(add(x2, y2)) > FOUR;
            always_comb begin
                n_lanes = '0;
                if (cubic) begin
                    n_lanes[0] = mul(x2, x);
                    n_lanes[1] = mul(x, y2);
                    n_lanes[2] = mul(x2, y);
                    n_lanes[3] = mul(y2, y);
                end else if (quartic) begin
                    n_lanes[0] = mul(d, d);
                    n_lanes[1] = mul(x2, y2);
                    n_lanes[2] = mul(xy, d);
                end else begin
                    n_lanes[0] = d;
                    n_lanes[1] = add(xy, xy);
                end
            end
        end else begin : g_combine
            logic signed [W-1:0] m0, m1, m2, m3, tx, ty;
            assign m0 = i_lanes[0];
            assign m1 = i_lanes[1];
            assign m2 = i_lanes[2];
            assign m3 = i_lanes[3];
            always_comb begin
                if (cubic) begin
                    tx = sub(m0, x3(m1));
                    ty = conj ? sub(m3, x3(m2)) : sub(x3(m2), m3);
                end else if (quartic) begin
                    tx = sub(m0, x4(m1));
                    ty = conj ? neg(x4(m2)) : x4(m2);
                end else begin
                    tx = m0;
                    ty = conj ? neg(m1) : m1;
                end
                n_lanes = '0;
                if (i_load) begin
                    n_lanes = i_load_lanes;
                end else begin
                    n_lanes[0] = add(tx, i_ax);
                    n_lanes[1] = add(ty, i_ay);
                end
            end
            assign o_escape = 1'b0;
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (i_en || i_load) begin
            r_lanes <= n_lanes;
        end
    end

    assign o_lanes = r_lanes;

endmodule

@@ rtl/escape_time_fractal_iterator_core.sv @@
// Escape-time fractal iterator top level: config, sequencer and cell ring.
// Usage: write registers on i_cfg_we/i_cfg_index/i_cfg_data while idle.
// A pixel is taken on a clock edge with start high and busy low; busy
// stays high until the cycle in which the result strobe o_valid is shown,
// for one cycle, with o_escaped and o_iteration_count.
// Steps: the pixel is scaled and registered as it is taken, then offsets
// are added and the ring is loaded, then each iteration passes the square
// cell, cross-product cell and combine cell, and the result is registered
// when the point escapes or when it reaches the limit and stays inside.
// One pixel is in flight at a time; the three-cell ring sets the rate.
// Reset restores config, state and result registers; the block goes idle.
// The receiver cannot stall; each result is presented exactly once.
module escape_time_fractal_iterator_core import etf_pkg::*; #(
    parameter int FRAC_BITS   = 26,
    parameter int COORD_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic signed [12:0] i_pixel_col,
    input  logic signed [12:0] i_pixel_row,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output logic        o_valid,
    output logic        o_escaped,
    output logic [15:0] o_iteration_count
);

    localparam int W  = COORD_WIDTH;
    localparam int SW = 2 * W + 1;
    localparam logic signed [SW-1:0] MAXV = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [SW-1:0] MINV = ~MAXV;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_INIT = 3'b010,
        S_RUN  = 3'b100
    } t_state;

    typedef enum logic [2:0] {
        P_SQ   = 3'b001,
        P_CR   = 3'b010,
        P_CMB  = 3'b100
    } t_phase;

    function automatic logic signed [W-1:0] sat(input logic signed [SW-1:0] v);
        if (v > MAXV) return MAXV[W-1:0];
        if (v < MINV) return MINV[W-1:0];
        return v[W-1:0];
    endfunction

    t_kind               r_kind;
    logic [30:0]         r_scale;
    logic signed [31:0]  r_xoff, r_yoff, r_jre, r_jim;
    logic [15:0]         r_limit;

    t_state              r_state;
    t_phase              r_phase;
    logic [15:0]         r_iter;
    logic signed [W-1:0] r_px, r_py, r_ax, r_ay;
    logic                r_valid, r_escaped;
    logic [15:0]         r_count;

    logic [LANES-1:0][W-1:0] lanes0, lanes1, lanes2, load_lanes;
    logic                    escape;
    logic                    en0, en1, en2, load;
    logic signed [W-1:0]     cx, cy;
    logic signed [44:0]      pcol, prow;

    assign busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind  <= KIND_MANDEL;
            r_scale <= 31'd262144;
            r_xoff  <= '0;
            r_yoff  <= '0;
            r_jre   <= '0;
            r_jim   <= '0;
            r_limit <= 16'd256;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_KIND:  r_kind  <= t_kind'(i_cfg_data[2:0]);
                CFG_SCALE: r_scale <= i_cfg_data[30:0];
                CFG_XOFF:  r_xoff  <= i_cfg_data;
                CFG_YOFF:  r_yoff  <= i_cfg_data;
                CFG_JRE:   r_jre   <= i_cfg_data;
                CFG_JIM:   r_jim   <= i_cfg_data;
                CFG_LIMIT: r_limit <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign pcol = i_pixel_col * $signed({1'b0, r_scale});
    assign prow = i_pixel_row * $signed({1'b0, r_scale});

    assign cx = sat(SW'(r_px) + SW'(sat(SW'(r_xoff))));
    assign cy = sat(SW'(r_py) + SW'(sat(SW'(r_yoff))));

    always_comb begin
        load_lanes    = '0;
        load_lanes[0] = cx;
        load_lanes[1] = cy;
    end

    assign load = (r_state == S_INIT);
    assign en0  = (r_state == S_RUN) && (r_phase == P_SQ) && (r_iter != r_limit);
    assign en1  = (r_state == S_RUN) && (r_phase == P_CR) && !escape;
    assign en2  = (r_state == S_RUN) && (r_phase == P_CMB);

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_px <= sat(SW'(pcol));
            r_py <= sat(SW'(prow));
        end
        if (load) begin
            if (r_kind == KIND_JULIA || r_kind == KIND_CONJ_JULIA) begin
                r_ax <= sat(SW'(r_jre));
                r_ay <= sat(SW'(r_jim));
            end else begin
                r_ax <= cx;
                r_ay <= cy;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_phase   <= P_SQ;
            r_iter    <= '0;
            r_valid   <= 1'b0;
            r_escaped <= 1'b0;
            r_count   <= '0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_state <= S_INIT;
                    end
                end
                S_INIT: begin
                    r_state <= S_RUN;
                    r_phase <= P_SQ;
                    r_iter  <= '0;
                end
                S_RUN: begin
                    case (r_phase)
                        P_SQ: begin
                            if (r_iter == r_limit) begin
                                r_valid   <= 1'b1;
                                r_escaped <= 1'b0;
                                r_count   <= '0;
                                r_state   <= S_IDLE;
                            end else begin
                                r_phase <= P_CR;
                            end
                        end
                        P_CR: begin
                            if (escape) begin
                                r_valid   <= 1'b1;
                                r_escaped <= 1'b1;
                                r_count   <= r_iter;
                                r_state   <= S_IDLE;
                                r_phase   <= P_SQ;
                            end else begin
                                r_phase <= P_CMB;
                            end
                        end
                        default: begin
                            r_phase <= P_SQ;
                            r_iter  <= r_iter + 16'd1;
                        end
                    endcase
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    etf_cell #(.W(W), .F(FRAC_BITS), .STAGE(0)) u_cell0 (
        .i_clk        (i_clk),
        .i_en         (en0),
        .i_load       (1'b0),
        .i_kind       (r_kind),
        .i_lanes      (lanes2),
        .i_load_lanes (load_lanes),
        .i_ax         (r_ax),
        .i_ay         (r_ay),
        .o_lanes      (lanes0),
        .o_escape     ()
    );

    etf_cell #(.W(W), .F(FRAC_BITS), .STAGE(1)) u_cell1 (
        .i_clk        (i_clk),
        .i_en         (en1),
        .i_load       (1'b0),
        .i_kind       (r_kind),
        .i_lanes      (lanes0),
        .i_load_lanes (load_lanes),
        .i_ax         (r_ax),
        .i_ay         (r_ay),
        .o_lanes      (lanes1),
        .o_escape     (escape)
    );

    etf_cell #(.W(W), .F(FRAC_BITS), .STAGE(2)) u_cell2 (
        .i_clk        (i_clk),
        .i_en         (en2),
        .i_load       (load),
        .i_kind       (r_kind),
        .i_lanes      (lanes1),
        .i_load_lanes (load_lanes),
        .i_ax         (r_ax),
        .i_ay         (r_ay),
        .o_lanes      (lanes2),
        .o_escape     ()
    );

    assign o_valid           = r_valid;
    assign o_escaped         = r_escaped;
    assign o_iteration_count = r_count;

    a_inside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_escaped |-> o_iteration_count == 16'd0)
        else $error("inside result with nonzero count");

    a_idle_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while still busy");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_escaped |-> o_iteration_count < r_limit)
        else $error("escape count not below limit");

    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy && !o_valid)
        else $error("accepted item did not start work");

endmodule
